// ===== sv/itdt_pkg.sv =====
// Shared constants and types for the integer to decimal text block.
package itdt_pkg;

  localparam int NUM_W     = 64;               // input integer width
  localparam int NDIG      = 20;               // max decimal digits of a 64-bit magnitude
  localparam int DIG_W     = 4;                // one BCD digit
  localparam int BCD_W     = NDIG * DIG_W;
  localparam int STEP_BITS = 4;                // binary bits folded in per cycle
  localparam int NSTEPS    = NUM_W / STEP_BITS;
  localparam int CNT_W     = $clog2(NSTEPS);
  localparam int IDX_W     = $clog2(NDIG);
  localparam int CHAR_W    = 6;
  localparam int LEN_W     = 5;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef logic [NDIG-1:0][DIG_W-1:0] bcd_t;

endpackage

// ===== sv/itdt_dabble.sv =====
// Shift-and-add-3 step: folds STEP_BITS binary bits, MSB first, into a BCD accumulator.
module itdt_dabble (
  input  itdt_pkg::bcd_t                     bcd_in,
  input  logic [itdt_pkg::STEP_BITS-1:0]     bits_in,
  output itdt_pkg::bcd_t                     bcd_out
);
  import itdt_pkg::*;

  bcd_t             acc;
  logic [BCD_W-1:0] flat;

  always_comb begin
    acc  = bcd_in;
    flat = '0;
    for (int s = STEP_BITS - 1; s >= 0; s--) begin
      for (int d = 0; d < NDIG; d++) begin
        if (acc[d] >= 4'd5) begin
          acc[d] = acc[d] + 4'd3;
        end
      end
      // top digit never exceeds 4 here, so the bit shifted out is always zero
      flat = BCD_W'({acc, bits_in[s]});
      acc  = flat;
    end
    bcd_out = acc;
  end

endmodule

// ===== sv/integer_to_decimal_text_core.sv =====
// Signed 64-bit integer to decimal ASCII text, one character per output transfer.
//
// Input channel: in_valid / in_stall carry one signed 64-bit in_number. A
// transfer happens when in_valid is high and in_stall is low. in_stall stays
// high from the accepted transfer until the last character of that number
// has been taken, so one number is in flight at a time.
// Output channel: out_valid / out_stall carry out_text_char (ASCII '-' or a
// digit), out_is_last on the final character and out_text_length (1..20) on
// every character. Characters come most significant first, no leading zeros.
// Steps: the magnitude is folded into BCD four bits per cycle through one
// shift-and-add-3 unit in state ST_CONV, then state ST_LEN finds the digit
// count, and the characters follow from ST_SIGN (minus sign) and ST_DIGIT.
// A stalled output simply holds its character; nothing advances until the
// transfer. Reset (rst_n low, synchronous) returns to idle and drops any
// number in progress.
module integer_to_decimal_text_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [itdt_pkg::NUM_W-1:0]      in_number,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [itdt_pkg::CHAR_W-1:0]            out_text_char,
  output logic                                   out_is_last,
  output logic [itdt_pkg::LEN_W-1:0]             out_text_length
);
  import itdt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [NUM_W-1:0]  mag_r, mag_nxt;
  bcd_t              bcd_r, bcd_nxt, bcd_step;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  ndig;

  logic in_xfer, out_xfer;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_SIGN) || (state_r == ST_DIGIT);
  assign out_xfer  = out_valid && !out_stall;

  itdt_dabble u_dabble (
    .bcd_in  (bcd_r),
    .bits_in (mag_r[NUM_W-1 -: STEP_BITS]),
    .bcd_out (bcd_step)
  );

  // digit count: position of the highest nonzero digit, at least one
  always_comb begin
    ndig = LEN_W'(1);
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d] != '0) begin
        ndig = LEN_W'(d + 1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt   = in_number[NUM_W-1];
          mag_nxt   = in_number[NUM_W-1] ? (~in_number + NUM_W'(1)) : in_number;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_step;
        mag_nxt = {mag_r[NUM_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NSTEPS - 1)) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        len_nxt   = ndig + LEN_W'(neg_r);
        idx_nxt   = IDX_W'(ndig - LEN_W'(1));
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_xfer) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_xfer) begin
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    idx_r <= idx_nxt;
    len_r <= len_nxt;
  end

  assign out_text_char   = (state_r == ST_SIGN) ? CHAR_MINUS
                                                : CHAR_ZERO + {2'b00, bcd_r[idx_r]};
  assign out_is_last     = (state_r == ST_DIGIT) && (idx_r == '0);
  assign out_text_length = len_r;

  // no new number while characters of the current one are pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while output pending");

  // an accepted number goes straight into conversion
  a_xfer_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CONV) && !out_valid)
    else $error("conversion did not start");

  // a minus sign is never the whole text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_char == CHAR_MINUS) |-> !out_is_last)
    else $error("minus sign flagged last");

  // length stays within the 64-bit range
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_length >= LEN_W'(1)) && (out_text_length <= LEN_W'(NDIG)))
    else $error("text length out of range");

  // the last character ends the number
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_is_last) |=> !out_valid && !in_stall)
    else $error("output continued past last character");

endmodule

// ===== tb/tb.sv =====
// Testbench for integer_to_decimal_text_core: random and edge-case numbers checked per character.
module tb;
  import itdt_pkg::*;

  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          TAIL_CYCLES     = 40;
  localparam int          STALL_LIMIT     = 3000;
  localparam int          RANDOM_NUMBERS  = 380;
  localparam int          IDLE_PERCENT    = 13;
  localparam logic [63:0] RADIX           = 64'd10;
  localparam logic [63:0] MAX_POSITIVE    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              is_last;
    logic [LEN_W-1:0]  text_length;
  } text_symbol_t;

  class decimal_text_scoreboard;
    text_symbol_t expected_chars[$];
    int unsigned  errors;

    // Expands one accepted number into the characters the block should emit.
    function void note_number(logic signed [NUM_W-1:0] number);
      logic [NUM_W-1:0] magnitude;
      logic [3:0]       digits[$];
      logic             negative;
      int unsigned      total;
      text_symbol_t     sym;
      negative  = number[NUM_W-1];
      magnitude = negative ? (~number + 64'd1) : number;
      do begin
        digits.push_front(4'(magnitude % RADIX));
        magnitude = magnitude / RADIX;
      end while (magnitude != 0);
      total = digits.size() + (negative ? 1 : 0);
      if (negative) begin
        sym.text_char   = CHAR_MINUS;
        sym.is_last     = (total == 1);
        sym.text_length = LEN_W'(total);
        expected_chars.push_back(sym);
      end
      foreach (digits[k]) begin
        sym.text_char   = CHAR_ZERO + CHAR_W'(digits[k]);
        sym.is_last     = (k == digits.size() - 1);
        sym.text_length = LEN_W'(total);
        expected_chars.push_back(sym);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] text_char, logic is_last,
                             logic [LEN_W-1:0] text_length);
      text_symbol_t want;
      if (expected_chars.size() == 0) begin
        $error("character transfer with nothing expected: text_char %0d", text_char);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (text_char !== want.text_char) begin
        $error("text_char: expected %0d, got %0d", want.text_char, text_char);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("is_last: expected %0d, got %0d", want.is_last, is_last);
        errors++;
      end
      if (text_length !== want.text_length) begin
        $error("text_length: expected %0d, got %0d", want.text_length, text_length);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void report_leftover();
      if (expected_chars.size() != 0) begin
        $error("%0d characters never arrived", expected_chars.size());
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [NUM_W-1:0] in_number = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CHAR_W-1:0]       out_text_char;
  logic                    out_is_last;
  logic [LEN_W-1:0]        out_text_length;

  decimal_text_scoreboard sb = new();
  logic quiet = 1'b0;          // no idling on either side while set
  logic hold_request = 1'b0;
  int   hold_left = 0;
  int   cycles_without_transfer = 0;

  integer_to_decimal_text_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_number       (in_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_text_char   (out_text_char),
    .out_is_last     (out_is_last),
    .out_text_length (out_text_length)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left    <= HOLD_OFF_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_char(out_text_char, out_is_last, out_text_length);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      cycles_without_transfer <= 0;
    end else begin
      cycles_without_transfer <= cycles_without_transfer + 1;
      if (cycles_without_transfer >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic drive_number(input logic signed [NUM_W-1:0] number);
    while (!quiet && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (in_stall);
    sb.note_number(number);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [NUM_W-1:0] random_number();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] magnitude;
    int unsigned digit_count;
    logic        negative;
    negative = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: magnitude = 64'($urandom_range(1000));
      2: begin
        // uniform within a random digit count
        digit_count = $urandom_range(19, 1);
        lo = 64'd1;
        repeat (digit_count - 1) lo = lo * RADIX;
        hi = lo * RADIX - 64'd1;
        if (hi > MAX_POSITIVE) hi = MAX_POSITIVE;
        magnitude = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
      end
      default: magnitude = MAX_POSITIVE - 64'($urandom_range(50));
    endcase
    return negative ? (~magnitude + 64'd1) : magnitude;
  endfunction

  longint edge_numbers[] = '{
    0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
    999999999, 1000000000, -1000000000,
    64'sd999999999999999999, 64'sd1000000000000000000, -64'sd1000000000000000000,
    64'sd1234567890123456789,
    64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0001,
    64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA
  };

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (edge_numbers[k]) drive_number(edge_numbers[k]);

    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      if (n == 60) hold_request <= 1'b1;
      if (n == 150) quiet <= 1'b1;
      if (n == 230) quiet <= 1'b0;
      if (n == 300) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      drive_number(random_number());
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
